[hw/rtl/iir_df1_pkg.sv]
`timescale 1ns / 1ps

package iir_df1_pkg;

  // Field and register widths.
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = 37;
  localparam int QUOT_W     = 17;
  localparam int REM_W      = COEF_W + 1;
  localparam int REG_IDX_W  = 3;
  localparam int TERM_W     = 3;
  localparam int TAP_W      = 2;
  localparam int HIST_DEPTH = 3;
  localparam int HIST_IDX_W = 2;
  localparam int STEP_W     = 5;

  // Highest filter order the datapath supports, and the default.
  localparam int MAX_ORDER     = 3;
  localparam int DEFAULT_ORDER = 3;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_B3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_A0 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_A3 = 3'd7;

  // Unity gain in Q1.16 and the output clip limits.
  localparam logic signed [COEF_W-1:0]   COEF_ONE   = 18'sd65536;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              mul_en;
    logic [TERM_W-1:0] term;
    logic              acc_en;
    logic              abs_en;
    logic              div_init;
    logic              div_step;
    logic              finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

[hw/rtl/iir_df1_if.sv]
`timescale 1ns / 1ps

// Input sample channel.
interface iir_df1_sample_if
  import iir_df1_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

// Filtered result channel.
interface iir_df1_result_if
  import iir_df1_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       saturated;
  logic                       divide_fault;

  modport source (output valid, output sample_out, output saturated,
                  output divide_fault, input ready);
  modport sink (input valid, input sample_out, input saturated,
                input divide_fault, output ready);
endinterface

[hw/rtl/iir_df1_ctrl.sv]
`timescale 1ns / 1ps

module iir_df1_ctrl
  import iir_df1_pkg::*;
#(
  parameter int ORDER = DEFAULT_ORDER
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  status_t status,
  output logic    ready,
  output cmd_t    cmd
);

  localparam int NumTerms = 2 * ORDER + 1;

  typedef enum logic [2:0] {
    IDLE,
    MAC,
    DRAIN,
    ABS,
    INIT,
    DIV,
    FINISH
  } state_t;

  state_t            state;
  logic [TERM_W-1:0] term_cnt;
  logic [STEP_W-1:0] step_cnt;

  // Sequencer: multiply-accumulate over the taps, then a bit-serial divide.
  // The command outputs are registered and act in the cycle after they are set.
  // Ready stays low through reset and rises on the first idle cycle after it.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      ready    <= 1'b0;
      term_cnt <= '0;
      step_cnt <= '0;
      cmd      <= '0;
    end else begin
      cmd <= '0;
      case (state)
        IDLE: begin
          if (accept) begin
            ready        <= 1'b0;
            state        <= MAC;
            term_cnt     <= '0;
            cmd.mul_en   <= 1'b1;
            cmd.term     <= '0;
          end else begin
            ready <= 1'b1;
          end
        end
        MAC: begin
          cmd.acc_en <= 1'b1;
          if (term_cnt == TERM_W'(NumTerms - 1)) begin
            state <= DRAIN;
          end else begin
            term_cnt   <= term_cnt + 1'b1;
            cmd.mul_en <= 1'b1;
            cmd.term   <= term_cnt + 1'b1;
          end
        end
        DRAIN: begin
          cmd.abs_en <= 1'b1;
          state      <= ABS;
        end
        ABS: begin
          cmd.div_init <= 1'b1;
          state        <= INIT;
        end
        INIT: begin
          cmd.div_step <= 1'b1;
          step_cnt     <= '0;
          state        <= DIV;
        end
        DIV: begin
          if (step_cnt == STEP_W'(QUOT_W - 1)) begin
            state <= FINISH;
          end else begin
            step_cnt     <= step_cnt + 1'b1;
            cmd.div_step <= 1'b1;
          end
        end
        FINISH: begin
          // Wait until the output register can take the new result.
          if (!status.out_busy) begin
            cmd.finish <= 1'b1;
            ready      <= 1'b1;
            state      <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
          ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

[hw/rtl/iir_df1_datapath.sv]
`timescale 1ns / 1ps

module iir_df1_datapath
  import iir_df1_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [REG_IDX_W-1:0]        cfg_index,
  input  logic [COEF_W-1:0]           cfg_data,
  input  logic                        load,
  input  logic signed [SAMPLE_W-1:0]  sample_in,
  input  cmd_t                        cmd,
  output status_t                     status,
  iir_df1_result_if.source            results
);

  logic signed [COEF_W-1:0]   coef_b [0:MAX_ORDER];
  logic signed [COEF_W-1:0]   coef_a [0:MAX_ORDER];
  logic signed [SAMPLE_W-1:0] x_cur;
  logic signed [SAMPLE_W-1:0] x_hist [0:HIST_DEPTH-1];
  logic signed [SAMPLE_W-1:0] y_hist [0:HIST_DEPTH-1];

  logic [TAP_W-1:0]           tap;
  logic [HIST_IDX_W-1:0]      hist_idx;
  logic                       term_fb;
  logic signed [COEF_W-1:0]   mul_coef;
  logic signed [SAMPLE_W-1:0] mul_smp;
  logic signed [PROD_W-1:0]   prod;
  logic                       prod_sub;
  logic signed [ACC_W-1:0]    acc;

  logic [ACC_W-1:0]           acc_mag;
  logic [COEF_W-1:0]          d_mag;
  logic                       neg;
  logic                       fault;
  logic                       ovf;
  logic [REM_W-1:0]           rem;
  logic [QUOT_W-1:0]          quot;
  logic [REM_W-1:0]           trial;
  logic                       trial_ge;

  logic signed [SAMPLE_W-1:0] y_next;
  logic                       sat_next;

  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_sat;
  logic                       out_fault;

  // Coefficient registers; the user must write them only while the filter is idle, as the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b[0] <= COEF_ONE;
      coef_b[1] <= '0;
      coef_b[2] <= '0;
      coef_b[3] <= '0;
      coef_a[0] <= COEF_ONE;
      coef_a[1] <= '0;
      coef_a[2] <= '0;
      coef_a[3] <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_B0:  coef_b[0] <= cfg_data;
        REG_B1:  coef_b[1] <= cfg_data;
        REG_B2:  coef_b[2] <= cfg_data;
        REG_B3:  coef_b[3] <= cfg_data;
        REG_A0:  coef_a[0] <= cfg_data;
        REG_A1:  coef_a[1] <= cfg_data;
        REG_A2:  coef_a[2] <= cfg_data;
        REG_A3:  coef_a[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Term selection: term 0 is b0*x, odd terms are feed-forward taps and
  // even terms are feedback taps, which are subtracted.
  always_comb begin
    tap      = TAP_W'((4'(cmd.term) + 4'd1) >> 1);
    hist_idx = HIST_IDX_W'(tap - 1'b1);
    term_fb  = (cmd.term != '0) && !cmd.term[0];
    if (cmd.term == '0) begin
      mul_coef = coef_b[0];
      mul_smp  = x_cur;
    end else if (term_fb) begin
      mul_coef = coef_a[tap];
      mul_smp  = y_hist[hist_idx];
    end else begin
      mul_coef = coef_b[tap];
      mul_smp  = x_hist[hist_idx];
    end
  end

  // Shared multiplier with a registered product, then the accumulator.
  always_ff @(posedge clk) begin
    if (load) begin
      x_cur <= sample_in;
      acc   <= '0;
    end else if (cmd.acc_en) begin
      if (prod_sub) begin
        acc <= acc - ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
    if (cmd.mul_en) begin
      prod     <= mul_coef * mul_smp;
      prod_sub <= term_fb;
    end
  end

  // Divide magnitudes, then restore the sign; this truncates toward zero.
  assign trial    = {rem[REM_W-2:0], quot[QUOT_W-1]};
  assign trial_ge = trial >= {1'b0, d_mag};

  always_ff @(posedge clk) begin
    if (cmd.abs_en) begin
      acc_mag <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
      d_mag   <= coef_a[0][COEF_W-1] ? COEF_W'(-coef_a[0]) : COEF_W'(coef_a[0]);
      neg     <= acc[ACC_W-1] ^ coef_a[0][COEF_W-1];
      fault   <= coef_a[0] == '0;
    end
    if (cmd.div_init) begin
      // A quotient of 2^17 or more clips whatever its low bits are.
      ovf  <= acc_mag >= ACC_W'({d_mag, {QUOT_W{1'b0}}});
      rem  <= acc_mag[QUOT_W+REM_W-1:QUOT_W];
      quot <= acc_mag[QUOT_W-1:0];
    end else if (cmd.div_step) begin
      rem  <= trial_ge ? trial - {1'b0, d_mag} : trial;
      quot <= {quot[QUOT_W-2:0], trial_ge};
    end
  end

  // Sign, clip and fault handling of the quotient.
  always_comb begin
    y_next   = '0;
    sat_next = 1'b0;
    if (fault) begin
      y_next = '0;
    end else if (ovf) begin
      sat_next = 1'b1;
      y_next   = neg ? SAMPLE_MIN : SAMPLE_MAX;
    end else if (!neg) begin
      if (quot > QUOT_W'(SAMPLE_MAX)) begin
        sat_next = 1'b1;
        y_next   = SAMPLE_MAX;
      end else begin
        y_next = quot[SAMPLE_W-1:0];
      end
    end else begin
      if (quot > QUOT_W'(17'd32768)) begin
        sat_next = 1'b1;
        y_next   = SAMPLE_MIN;
      end else begin
        y_next = SAMPLE_W'(-quot[SAMPLE_W-1:0]);
      end
    end
  end

  // Histories advance once per sample, when the result is committed.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        x_hist[i] <= '0;
        y_hist[i] <= '0;
      end
    end else if (cmd.finish) begin
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
        x_hist[i] <= x_hist[i-1];
        y_hist[i] <= y_hist[i-1];
      end
      x_hist[0] <= x_cur;
      y_hist[0] <= y_next;
    end
  end

  // Output register; the beat waits here until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_sample <= y_next;
      out_sat    <= sat_next;
      out_fault  <= fault;
    end
  end

  assign status.out_busy      = out_valid && !results.ready;
  assign results.valid        = out_valid;
  assign results.sample_out   = out_sample;
  assign results.saturated    = out_sat;
  assign results.divide_fault = out_fault;

endmodule

[hw/rtl/iir_direct_form_one.sv]
`timescale 1ns / 1ps

// Direct-form-I IIR filter of order ORDER (1 to 3) with Q1.16 coefficients
// and Q3.12 samples. A new sample is not taken until the last one is computed:
// one shared 18x16 multiplier runs one tap per cycle, then a restoring divider
// finds the 17-bit quotient by a0 one bit per cycle. The result is truncated
// toward zero, clipped to 16 bits with the saturated flag, and forced to zero
// with divide_fault when a0 is zero. A result waits in an output register, so
// the next sample is taken while it is still unread; that next sample then
// holds in its last step, with the input not ready, until the waiting beat is
// taken. Input ready is low during reset and rises after the first idle cycle.
// Coefficients are written through the cfg port; the user must write them only
// while idle, as the block does not enforce it.
module iir_direct_form_one
  import iir_df1_pkg::*;
#(
  parameter int ORDER = DEFAULT_ORDER
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  iir_df1_sample_if.sink       samples,
  iir_df1_result_if.source     results
);

  logic    accept;
  logic    ready;
  cmd_t    cmd;
  status_t status;

  // A sample beat is taken when the controller is idle.
  assign samples.ready = ready;
  assign accept        = samples.valid && ready;

  iir_df1_ctrl #(
    .ORDER (ORDER)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .status (status),
    .ready  (ready),
    .cmd    (cmd)
  );

  iir_df1_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .load      (accept),
    .sample_in (samples.sample_in),
    .cmd       (cmd),
    .status    (status),
    .results   (results)
  );

endmodule
